>>> hw/rtl/upps_pkg.sv
// Package for the UDP port frame steering block: codes, constants and shared types.
// No dependencies; every other file of the block imports it.
`default_nettype none

package upps_pkg;

    localparam int unsigned QUEUE_COUNT = 64;

    localparam logic [15:0] DEFAULT_PORT = 16'd2055;
    localparam logic [15:0] TYPE_IPV4    = 16'h0800;
    localparam logic [15:0] TYPE_IPV6    = 16'h86DD;
    localparam logic [15:0] TYPE_CTAG    = 16'h8100;
    localparam logic [15:0] TYPE_STAG    = 16'h88A8;
    localparam logic [7:0]  PROTO_UDP    = 8'd17;
    localparam logic [7:0]  IHL_MASK     = 8'h0F;

    // Header offsets within the frame.
    localparam logic [6:0] OFF_TYPE_HI     = 7'd12;
    localparam logic [6:0] OFF_TYPE_LO     = 7'd13;
    localparam logic [6:0] OFF_TAG_TYPE_HI = 7'd16;
    localparam logic [6:0] OFF_TAG_TYPE_LO = 7'd17;
    localparam logic [4:0] NET_START_PLAIN  = 5'd14;
    localparam logic [4:0] NET_START_TAGGED = 5'd18;
    localparam logic [6:0] OFFSET_MAX      = 7'd127;

    localparam logic [6:0] V4_REL_IHL   = 7'd0;
    localparam logic [6:0] V4_REL_PROTO = 7'd9;
    localparam logic [6:0] V6_REL_NEXT  = 7'd6;
    localparam logic [7:0] V4_MIN_LEN   = 8'd20;
    localparam logic [6:0] V6_HDR_LEN   = 7'd40;
    localparam logic [7:0] UDP_HDR_LEN  = 8'd8;
    localparam logic [3:0] IHL_MIN      = 4'd5;

    typedef logic [7:0]  t_byte;
    typedef logic [5:0]  t_queue;
    typedef logic [15:0] t_port;
    typedef logic [63:0] t_cfg_data;

    typedef enum logic [0:0] {
        CFG_TARGET_PORT = 1'b0,
        CFG_SOCKET_MASK = 1'b1
    } t_cfg_index;

    typedef enum logic [1:0] {
        KIND_UNKNOWN = 2'd0,
        KIND_V4      = 2'd1,
        KIND_V6      = 2'd2,
        KIND_OTHER   = 2'd3
    } t_kind;

    typedef enum logic [2:0] {
        REASON_REDIRECT  = 3'd0,
        REASON_TRUNCATED = 3'd1,
        REASON_NOT_IP    = 3'd2,
        REASON_BAD_IHL   = 3'd3,
        REASON_NOT_UDP   = 3'd4,
        REASON_PORT_MISS = 3'd5,
        REASON_NO_SOCKET = 3'd6
    } t_reason;

    typedef struct packed {
        logic    verdict;
        t_queue  queue_index;
        t_reason pass_reason;
    } t_result;

endpackage

`default_nettype wire

>>> hw/rtl/upps_if.sv
// Handshake channel interfaces of the steering block: frame bytes, verdicts, configuration.
// Depends on upps_pkg.
`default_nettype none

interface upps_in_if;
    import upps_pkg::*;
    logic   valid;
    logic   ready;
    t_byte  data_byte;
    logic   last_byte;
    t_queue rx_queue;

    modport source (output valid, output data_byte, output last_byte, output rx_queue,
                    input ready);
    modport sink   (input valid, input data_byte, input last_byte, input rx_queue,
                    output ready);
endinterface

interface upps_out_if;
    import upps_pkg::*;
    logic   valid;
    logic   ready;
    logic   verdict;
    t_queue queue_index;
    logic [2:0] pass_reason;

    modport source (output valid, output verdict, output queue_index, output pass_reason,
                    input ready);
    modport sink   (input valid, input verdict, input queue_index, input pass_reason,
                    output ready);
endinterface

interface upps_cfg_if;
    import upps_pkg::*;
    logic       valid;
    logic       ready;
    t_cfg_index index;
    t_cfg_data  data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

>>> hw/rtl/upps_parse.sv
// Frame header parser and verdict logic: holds the per-frame parse state.
// Depends on upps_pkg.
`default_nettype none

module upps_parse (
    input  wire                i_clk,
    input  wire                i_rst_n,
    input  wire                i_step,
    input  upps_pkg::t_byte    i_data_byte,
    input  wire                i_last_byte,
    input  upps_pkg::t_queue   i_rx_queue,
    input  upps_pkg::t_port    i_target_port,
    input  upps_pkg::t_cfg_data i_socket_mask,
    output upps_pkg::t_result  o_result
);
    import upps_pkg::*;

    logic [6:0]  r_byte_offset,     n_byte_offset;
    logic [15:0] r_ether_type,      n_ether_type;
    logic [4:0]  r_network_start,   n_network_start;
    logic [6:0]  r_transport_start, n_transport_start;
    t_kind       r_header_kind,     n_header_kind;
    logic [7:0]  r_next_protocol,   n_next_protocol;
    t_port       r_captured_port,   n_captured_port;
    logic        r_malformed,       n_malformed;

    logic [6:0] off;
    logic [6:0] net_start_w;
    logic [6:0] rel;
    logic [3:0] ihl;
    logic [7:0] len;
    t_port      port;
    t_reason    reason;

    assign off         = r_byte_offset;
    assign len         = {1'b0, off} + 8'd1;
    assign port        = (i_target_port != '0) ? i_target_port : DEFAULT_PORT;

    // Parse one byte; later steps see the updates of earlier ones, as in the spec order.
    always_comb begin
        n_ether_type      = r_ether_type;
        n_network_start   = r_network_start;
        n_transport_start = r_transport_start;
        n_header_kind     = r_header_kind;
        n_next_protocol   = r_next_protocol;
        n_captured_port   = r_captured_port;
        n_malformed       = r_malformed;
        net_start_w       = 7'd0;
        rel               = 7'd0;
        ihl               = 4'd0;

        if (off == OFF_TYPE_HI) begin
            n_ether_type = {i_data_byte, 8'h00};
        end else if (off == OFF_TYPE_LO) begin
            n_ether_type = {r_ether_type[15:8], i_data_byte};
        end else if (r_network_start == NET_START_TAGGED && off == OFF_TAG_TYPE_HI) begin
            n_ether_type = {i_data_byte, 8'h00};
        end else if (r_network_start == NET_START_TAGGED && off == OFF_TAG_TYPE_LO) begin
            n_ether_type = {r_ether_type[15:8], i_data_byte};
        end

        net_start_w = {2'b00, r_network_start};
        if (off == OFF_TYPE_LO &&
            (n_ether_type == TYPE_CTAG || n_ether_type == TYPE_STAG)) begin
            n_network_start = NET_START_TAGGED;
        end else if (off == OFF_TYPE_LO ||
                     (r_network_start == NET_START_TAGGED && off == OFF_TAG_TYPE_LO)) begin
            if (n_ether_type == TYPE_IPV4) begin
                n_header_kind = KIND_V4;
            end else if (n_ether_type == TYPE_IPV6) begin
                n_header_kind     = KIND_V6;
                n_transport_start = net_start_w + V6_HDR_LEN;
            end else begin
                n_header_kind = KIND_OTHER;
            end
        end

        net_start_w = {2'b00, n_network_start};
        rel         = off - net_start_w;
        ihl         = i_data_byte[3:0] & IHL_MASK[3:0];
        if (off >= net_start_w && n_header_kind == KIND_V4) begin
            if (rel == V4_REL_IHL) begin
                n_transport_start = net_start_w + {1'b0, ihl, 2'b00};
                n_malformed       = (ihl < IHL_MIN);
            end else if (rel == V4_REL_PROTO) begin
                n_next_protocol = i_data_byte;
            end
        end else if (off >= net_start_w && n_header_kind == KIND_V6) begin
            if (rel == V6_REL_NEXT) begin
                n_next_protocol = i_data_byte;
            end
        end

        if (n_transport_start != '0 && off > net_start_w) begin
            if (off == n_transport_start + 7'd2) begin
                n_captured_port = {i_data_byte, 8'h00};
            end else if (off == n_transport_start + 7'd3) begin
                n_captured_port = {n_captured_port[15:8], i_data_byte};
            end
        end

        n_byte_offset = (r_byte_offset < OFFSET_MAX) ? r_byte_offset + 7'd1 : r_byte_offset;
    end

    // Verdict for a frame ending at this byte, in check priority order.
    always_comb begin
        logic [7:0] ns8;
        logic [7:0] ts8;
        ns8 = {3'b000, n_network_start};
        ts8 = {1'b0, n_transport_start};
        reason = REASON_REDIRECT;
        if (len < 8'd14) begin
            reason = REASON_TRUNCATED;
        end else if (n_network_start == NET_START_TAGGED && len < 8'd18) begin
            reason = REASON_TRUNCATED;
        end else if (n_header_kind == KIND_V4 && len < ns8 + V4_MIN_LEN) begin
            reason = REASON_TRUNCATED;
        end else if (n_header_kind == KIND_V4 && n_malformed) begin
            reason = REASON_BAD_IHL;
        end else if (n_header_kind == KIND_V4 && len < ts8) begin
            reason = REASON_TRUNCATED;
        end else if (n_header_kind == KIND_V6 && len < ns8 + {1'b0, V6_HDR_LEN}) begin
            reason = REASON_TRUNCATED;
        end else if (n_header_kind != KIND_V4 && n_header_kind != KIND_V6) begin
            reason = REASON_NOT_IP;
        end else if (n_next_protocol != PROTO_UDP) begin
            reason = REASON_NOT_UDP;
        end else if (len < ts8 + UDP_HDR_LEN) begin
            reason = REASON_TRUNCATED;
        end else if (n_captured_port != port) begin
            reason = REASON_PORT_MISS;
        end else if ({1'b0, i_rx_queue} >= 7'(QUEUE_COUNT) ||
                     !i_socket_mask[i_rx_queue]) begin
            reason = REASON_NO_SOCKET;
        end
    end

    assign o_result.verdict     = (reason == REASON_REDIRECT);
    assign o_result.queue_index = (reason == REASON_REDIRECT) ? i_rx_queue : '0;
    assign o_result.pass_reason = reason;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || (i_step && i_last_byte)) begin
            r_byte_offset     <= '0;
            r_ether_type      <= '0;
            r_network_start   <= NET_START_PLAIN;
            r_transport_start <= '0;
            r_header_kind     <= KIND_UNKNOWN;
            r_next_protocol   <= '0;
            r_captured_port   <= '0;
            r_malformed       <= 1'b0;
        end else if (i_step) begin
            r_byte_offset     <= n_byte_offset;
            r_ether_type      <= n_ether_type;
            r_network_start   <= n_network_start;
            r_transport_start <= n_transport_start;
            r_header_kind     <= n_header_kind;
            r_next_protocol   <= n_next_protocol;
            r_captured_port   <= n_captured_port;
            r_malformed       <= n_malformed;
        end
    end

endmodule

`default_nettype wire

>>> hw/rtl/udp_port_packet_steer_top.sv
// Top level of the UDP destination port frame steering block.
// Depends on upps_pkg, the channel interfaces in upps_if and the parser upps_parse.
//
// Usage:
//   i_in carries an Ethernet frame one byte per transfer, from the destination
//   MAC onward, with last_byte marking the final byte and rx_queue giving the
//   receive queue of the frame (sampled with the final byte). o_out carries one
//   verdict per frame: redirect to the queue socket, or pass with a reason code.
//   i_cfg writes the target port (index 0, zero selects 2055) and the 64-bit
//   queue socket mask (index 1); it is always ready and should only be used
//   while no frame is in flight.
//
// Timing:
//   A byte is registered at the transfer edge; the parser and verdict logic sit
//   between that input register and the result register, so the verdict for a
//   frame is offered on o_out from the result register once its final byte has left the input register.
//   One byte is accepted per cycle, sustained, as long as o_out keeps draining.
//
// Reset and stalls:
//   Reset clears both configuration registers, the parse state and the valid flags. When the
//   receiver holds off o_out, the verdict waits in the result register; bytes
//   that produce no verdict keep flowing, and a final byte waits in the input
//   register until the result register frees up, which then backpressures i_in.
`default_nettype none

module udp_port_packet_steer_top (
    input  wire        i_clk,
    input  wire        i_rst_n,
    upps_in_if.sink    i_in,
    upps_out_if.source o_out,
    upps_cfg_if.sink   i_cfg
);
    import upps_pkg::*;

    // Configuration registers.
    t_port     r_target_port;
    t_cfg_data r_socket_mask;

    // Input register stage.
    logic   r_s1_valid;
    t_byte  r_s1_data;
    logic   r_s1_last;
    t_queue r_s1_queue;

    // Result register stage.
    logic    r_out_valid;
    t_result r_out;

    t_result parse_result;
    logic    out_free;
    logic    s1_adv;
    logic    in_take;

    // A byte leaves the input stage freely unless it closes a frame, in which
    // case the result register must be able to take the verdict.
    assign out_free = !r_out_valid || o_out.ready;
    assign s1_adv   = r_s1_valid && (!r_s1_last || out_free);
    assign in_take  = i_in.valid && i_in.ready;

    assign i_in.ready  = !r_s1_valid || s1_adv;
    assign i_cfg.ready = 1'b1;

    assign o_out.valid       = r_out_valid;
    assign o_out.verdict     = r_out.verdict;
    assign o_out.queue_index = r_out.queue_index;
    assign o_out.pass_reason = r_out.pass_reason;

    upps_parse u_parse (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_step        (s1_adv),
        .i_data_byte   (r_s1_data),
        .i_last_byte   (r_s1_last),
        .i_rx_queue    (r_s1_queue),
        .i_target_port (r_target_port),
        .i_socket_mask (r_socket_mask),
        .o_result      (parse_result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_target_port <= '0;
            r_socket_mask <= '0;
        end else if (i_cfg.valid) begin
            case (i_cfg.index)
                CFG_TARGET_PORT: r_target_port <= i_cfg.data[15:0];
                CFG_SOCKET_MASK: r_socket_mask <= i_cfg.data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (in_take) begin
            r_s1_valid <= 1'b1;
        end else if (s1_adv) begin
            r_s1_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_s1_data  <= i_in.data_byte;
            r_s1_last  <= i_in.last_byte;
            r_s1_queue <= i_in.rx_queue;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (s1_adv && r_s1_last) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_adv && r_s1_last) begin
            r_out <= parse_result;
        end
    end

endmodule

`default_nettype wire

>>> tb/sv/upps_steer_checker.sv
// Verdict checker for the UDP port frame steering block: it follows the byte, verdict and
// register channels, predicts each verdict from the accepted bytes and compares it.
// Depends on upps_pkg.
module upps_steer_checker
    import upps_pkg::*;
(
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         i_in_valid,
    input  wire         i_in_ready,
    input  t_byte       i_in_data,
    input  wire         i_in_last,
    input  t_queue      i_in_queue,
    input  wire         i_out_valid,
    input  wire         i_out_ready,
    input  wire         i_out_verdict,
    input  t_queue      i_out_queue,
    input  logic [2:0]  i_out_reason,
    input  wire         i_cfg_valid,
    input  wire         i_cfg_ready,
    input  t_cfg_index  i_cfg_index,
    input  t_cfg_data   i_cfg_data,
    output int          o_fail_count,
    output int          o_pending,
    output int          o_verdicts,
    output int          o_redirects
);
    timeunit 1ns;
    timeprecision 1ps;

    // Register copies.
    t_port       cfg_port;
    t_cfg_data   cfg_mask;

    // Parse state of the frame in progress.
    logic [6:0]  off_cnt;
    logic [15:0] eth_type;
    logic [4:0]  net_start;
    logic [6:0]  trans_start;
    t_kind       kind;
    logic [7:0]  l4_proto;
    t_port       dport;
    logic        bad_ihl;

    t_result     verdict_q[$];

    task automatic restart_frame();
        off_cnt     = '0;
        eth_type    = '0;
        net_start   = NET_START_PLAIN;
        trans_start = '0;
        kind        = KIND_UNKNOWN;
        l4_proto    = '0;
        dport       = '0;
        bad_ihl     = 1'b0;
    endtask

    task automatic resolve_kind();
        if (eth_type == TYPE_IPV4) begin
            kind = KIND_V4;
        end else if (eth_type == TYPE_IPV6) begin
            kind        = KIND_V6;
            trans_start = 7'(int'(net_start) + int'(V6_HDR_LEN));
        end else begin
            kind = KIND_OTHER;
        end
    endtask

    task automatic parse_byte(input t_byte b, input int off);
        int ns;
        int ts;
        int rel;
        logic [3:0] ihl;
        // Outer type, then the inner type behind one tag.
        if (off == OFF_TYPE_HI) begin
            eth_type = {b, 8'h00};
        end else if (off == OFF_TYPE_LO) begin
            eth_type[7:0] = b;
            if (eth_type == TYPE_CTAG || eth_type == TYPE_STAG) begin
                net_start = NET_START_TAGGED;
            end else begin
                resolve_kind();
            end
        end else if (net_start == NET_START_TAGGED && off == OFF_TAG_TYPE_HI) begin
            eth_type = {b, 8'h00};
        end else if (net_start == NET_START_TAGGED && off == OFF_TAG_TYPE_LO) begin
            eth_type[7:0] = b;
            resolve_kind();
        end

        ns = net_start;
        if (off >= ns && kind == KIND_V4) begin
            rel = off - ns;
            if (rel == V4_REL_IHL) begin
                ihl         = b[3:0] & IHL_MASK[3:0];
                trans_start = 7'(ns + int'(ihl) * 4);
                bad_ihl     = ihl < IHL_MIN;
            end else if (rel == V4_REL_PROTO) begin
                l4_proto = b;
            end
        end else if (off >= ns && kind == KIND_V6) begin
            if (off - ns == V6_REL_NEXT) begin
                l4_proto = b;
            end
        end

        ts = trans_start;
        if (ts != 0 && off > ns) begin
            if (off == ts + 2) begin
                dport = {b, 8'h00};
            end else if (off == ts + 3) begin
                dport[7:0] = b;
            end
        end
    endtask

    function automatic t_reason steer_reason(input int len, input t_queue q);
        t_port wanted;
        int ns;
        int ts;
        wanted = (cfg_port != '0) ? cfg_port : DEFAULT_PORT;
        ns = net_start;
        ts = trans_start;
        if (len < NET_START_PLAIN) return REASON_TRUNCATED;
        if (net_start == NET_START_TAGGED && len < NET_START_TAGGED) return REASON_TRUNCATED;
        if (kind == KIND_V4) begin
            if (len < ns + int'(V4_MIN_LEN)) return REASON_TRUNCATED;
            if (bad_ihl) return REASON_BAD_IHL;
            if (len < ts) return REASON_TRUNCATED;
        end else if (kind == KIND_V6) begin
            if (len < ns + int'(V6_HDR_LEN)) return REASON_TRUNCATED;
        end else begin
            return REASON_NOT_IP;
        end
        if (l4_proto != PROTO_UDP) return REASON_NOT_UDP;
        if (len < ts + int'(UDP_HDR_LEN)) return REASON_TRUNCATED;
        if (dport != wanted) return REASON_PORT_MISS;
        if (int'(q) >= QUEUE_COUNT || !cfg_mask[q]) return REASON_NO_SOCKET;
        return REASON_REDIRECT;
    endfunction

    task automatic check_field(input string field, input logic [7:0] want,
                               input logic [7:0] got);
        if (got !== want) begin
            o_fail_count++;
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
        end
    endtask

    always @(posedge i_clk) begin : verdict_check
        t_result expected;
        t_reason why;
        int off;
        if (!i_rst_n) begin
            cfg_port = '0;
            cfg_mask = '0;
            restart_frame();
            verdict_q.delete();
            o_fail_count = 0;
            o_pending    = 0;
            o_verdicts   = 0;
            o_redirects  = 0;
        end else begin
            if (i_cfg_valid && i_cfg_ready) begin
                if (i_cfg_index == CFG_TARGET_PORT) begin
                    cfg_port = i_cfg_data[15:0];
                end else if (i_cfg_index == CFG_SOCKET_MASK) begin
                    cfg_mask = i_cfg_data;
                end
            end

            // A verdict leaving now belongs to an earlier byte, so compare before predicting.
            if (i_out_valid && i_out_ready) begin
                if (verdict_q.size() == 0) begin
                    o_fail_count++;
                    $display("%0t: verdict transfer with none expected: verdict %0d queue %0d reason %0d",
                             $time, i_out_verdict, i_out_queue, i_out_reason);
                end else begin
                    expected = verdict_q.pop_front();
                    check_field("verdict", expected.verdict, i_out_verdict);
                    check_field("queue_index", expected.queue_index, i_out_queue);
                    check_field("pass_reason", expected.pass_reason, i_out_reason);
                    o_verdicts++;
                    if (expected.verdict) o_redirects++;
                end
            end

            if (i_in_valid && i_in_ready) begin
                off = off_cnt;
                parse_byte(i_in_data, off);
                if (off_cnt != OFFSET_MAX) off_cnt = off_cnt + 7'd1;
                if (i_in_last) begin
                    why = steer_reason(off + 1, i_in_queue);
                    expected.verdict     = (why == REASON_REDIRECT);
                    expected.queue_index = (why == REASON_REDIRECT) ? i_in_queue : '0;
                    expected.pass_reason = why;
                    verdict_q.push_back(expected);
                    restart_frame();
                end
            end
            o_pending = verdict_q.size();
        end
    end

endmodule

>>> tb/sv/udp_port_packet_steer_top_test.sv
// Testbench top for udp_port_packet_steer_top: clock, reset, frame and register stimulus,
// output back-pressure and the final verdict. Depends on upps_pkg, the channel interfaces
// and upps_steer_checker, which does all prediction and comparison.
module udp_port_packet_steer_top_test;
    timeunit 1ns;
    timeprecision 1ps;
    import upps_pkg::*;

    localparam int CYCLE_LIMIT  = 200000;
    localparam int HOLD_CYCLES  = 300;
    localparam int RANDOM_BYTES = 600;
    localparam int PHASE_FRAMES = 3;
    localparam logic [15:0] NO_TAG = 16'h0000;

    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;

    // Stimulus controls shared between the sender and the receiver processes.
    logic      idle_on;
    logic      hold_request;
    t_port     cur_port;
    t_cfg_data cur_mask;

    int cycle_count = 0;
    int frames_sent = 0;
    int bytes_sent  = 0;
    int settings_used = 1;

    // Results handed up by the checker.
    int fail_count;
    int pending;
    int verdict_count;
    int redirect_count;

    upps_in_if  in_ch ();
    upps_out_if out_ch ();
    upps_cfg_if cfg_ch ();

    udp_port_packet_steer_top i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch),
        .i_cfg   (cfg_ch)
    );

    upps_steer_checker i_checker (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (in_ch.valid),
        .i_in_ready    (in_ch.ready),
        .i_in_data     (in_ch.data_byte),
        .i_in_last     (in_ch.last_byte),
        .i_in_queue    (in_ch.rx_queue),
        .i_out_valid   (out_ch.valid),
        .i_out_ready   (out_ch.ready),
        .i_out_verdict (out_ch.verdict),
        .i_out_queue   (out_ch.queue_index),
        .i_out_reason  (out_ch.pass_reason),
        .i_cfg_valid   (cfg_ch.valid),
        .i_cfg_ready   (cfg_ch.ready),
        .i_cfg_index   (cfg_ch.index),
        .i_cfg_data    (cfg_ch.data),
        .o_fail_count  (fail_count),
        .o_pending     (pending),
        .o_verdicts    (verdict_count),
        .o_redirects   (redirect_count)
    );

    // 12 ns clock period.
    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // Watchdog: a run that hangs on a handshake ends here as a failure.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("%0t: run stopped after %0d cycles without draining", $time, cycle_count);
            $display("udp_port_packet_steer_top test failed");
            $finish;
        end
    end

    // Receiver side. Ready changes only at the falling edge. Normally it drops at random,
    // seven times in a hundred; on request it holds off for a long, counted stretch so
    // that the result register and then the input register fill and the block stalls
    // its byte input.
    initial begin
        out_ch.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_request) begin
                out_ch.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge i_clk);
                hold_request = 1'b0;
            end else begin
                out_ch.ready <= !(idle_on && $urandom_range(0, 99) < 7);
            end
        end
    end

    function automatic t_byte rand_byte();
        return t_byte'($urandom_range(0, 255));
    endfunction

    // Offers the bytes of one frame, one transfer each, starting at a falling edge. The
    // receive queue is only meaningful with the final byte, so the others carry noise.
    // Valid is left high after the last transfer; whoever pauses next lowers it.
    task automatic send_frame(input t_byte frame[$], input t_queue q);
        int i;
        logic last_flag;
        for (i = 0; i < frame.size(); i++) begin
            last_flag = (i == frame.size() - 1);
            if (idle_on && $urandom_range(0, 99) < 5) begin
                in_ch.valid <= 1'b0;
                repeat ($urandom_range(1, 2)) @(negedge i_clk);
            end
            in_ch.valid     <= 1'b1;
            in_ch.data_byte <= frame[i];
            in_ch.last_byte <= last_flag;
            in_ch.rx_queue  <= last_flag ? q : t_queue'($urandom_range(0, 63));
            do @(posedge i_clk); while (!in_ch.ready);
            @(negedge i_clk);
            bytes_sent++;
        end
        frames_sent++;
    endtask

    // Builds a frame from header choices and sends it. A zero tag type means untagged.
    // Any type other than IPv4 or IPv6 gets no network header, so a tag type there makes
    // a nested tag. A nonzero cut length truncates the frame to that many bytes.
    task automatic steer_frame(input logic [15:0] tag_type, input logic [15:0] net_type,
                               input logic [3:0] ihl, input t_byte proto, input t_port dp,
                               input int tail_bytes, input int cut_len, input t_queue q);
        t_byte frame[$];
        int i;
        frame = {};
        repeat (12) frame.push_back(rand_byte());
        if (tag_type != NO_TAG) begin
            frame.push_back(tag_type[15:8]);
            frame.push_back(tag_type[7:0]);
            repeat (2) frame.push_back(rand_byte());
        end
        frame.push_back(net_type[15:8]);
        frame.push_back(net_type[7:0]);
        if (net_type == TYPE_IPV4) begin
            // The version nibble is random; only the IHL nibble matters.
            frame.push_back({4'($urandom_range(0, 15)), ihl});
            for (i = 1; i < V4_MIN_LEN; i++) begin
                frame.push_back((i == V4_REL_PROTO) ? proto : rand_byte());
            end
            if (ihl > IHL_MIN) begin
                repeat ((int'(ihl) - int'(IHL_MIN)) * 4) frame.push_back(rand_byte());
            end
        end else if (net_type == TYPE_IPV6) begin
            for (i = 0; i < V6_HDR_LEN; i++) begin
                frame.push_back((i == V6_REL_NEXT) ? proto : rand_byte());
            end
        end
        // Transport header: source port, destination port, length and checksum.
        repeat (2) frame.push_back(rand_byte());
        frame.push_back(dp[15:8]);
        frame.push_back(dp[7:0]);
        repeat (4) frame.push_back(rand_byte());
        repeat (tail_bytes) frame.push_back(rand_byte());
        if (cut_len > 0) begin
            while (frame.size() > cut_len) void'(frame.pop_back());
        end
        send_frame(frame, q);
    endtask

    // Stops offering bytes and waits at falling edges until every predicted verdict has
    // been seen, then waits at further falling edges so nothing is left inside the block.
    task automatic wait_drained();
        in_ch.valid <= 1'b0;
        while (pending != 0) @(negedge i_clk);
        repeat (4) @(negedge i_clk);
    endtask

    // One register write transfer, starting at a falling edge. Valid stays high so that
    // writes can follow back to back; the caller lowers it afterwards.
    task automatic write_reg(input t_cfg_index idx, input t_cfg_data value);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= value;
        do @(posedge i_clk); while (!cfg_ch.ready);
        @(negedge i_clk);
    endtask

    // Registers only change while no frame is in flight.
    task automatic apply_setting(input t_port new_port, input t_cfg_data new_mask);
        wait_drained();
        write_reg(CFG_TARGET_PORT, t_cfg_data'(new_port));
        write_reg(CFG_SOCKET_MASK, new_mask);
        cfg_ch.valid <= 1'b0;
        cur_port = new_port;
        cur_mask = new_mask;
        settings_used++;
    endtask

    initial begin
        int phase;
        int f0;
        int b0;
        int r;
        int n;
        logic [15:0] tag;
        logic [15:0] net;
        logic [3:0]  ihl;
        t_byte       proto;
        t_port       dp;
        t_port       eff;
        int          payload;
        int          cut;
        t_queue      q;
        t_byte       noise[$];

        in_ch.valid     = 1'b0;
        in_ch.data_byte = '0;
        in_ch.last_byte = 1'b0;
        in_ch.rx_queue  = '0;
        cfg_ch.valid    = 1'b0;
        cfg_ch.index    = CFG_TARGET_PORT;
        cfg_ch.data     = '0;
        idle_on         = 1'b1;
        hold_request    = 1'b0;
        cur_port        = '0;
        cur_mask        = '0;

        repeat (12) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Directed frames. With the reset registers the port defaults to 2055 and no
        // socket is bound, so a well-formed frame passes for lack of a socket.
        steer_frame(NO_TAG, TYPE_IPV4, 4'd5, PROTO_UDP, DEFAULT_PORT, 4, 0, 6'd5);

        // Port register zero selects the default port; every queue has a socket.
        apply_setting(16'd0, '1);
        steer_frame(NO_TAG, TYPE_IPV4, 4'd5, PROTO_UDP, DEFAULT_PORT, 0, 0, 6'd0);
        steer_frame(NO_TAG, TYPE_IPV6, 4'd5, PROTO_UDP, DEFAULT_PORT, 3, 0, 6'd63);
        // Customer tag in front of IPv4 with two option words.
        steer_frame(TYPE_CTAG, TYPE_IPV4, 4'd7, PROTO_UDP, DEFAULT_PORT, 2, 0, 6'd63);
        // Service tag and IPv6 with a payload that runs the byte offset into saturation.
        steer_frame(TYPE_STAG, TYPE_IPV6, 4'd5, PROTO_UDP, DEFAULT_PORT, 120, 0, 6'd17);
        // Truncation at each stage of the header walk.
        steer_frame(NO_TAG, TYPE_IPV4, 4'd5, PROTO_UDP, DEFAULT_PORT, 0, 1, 6'd0);
        steer_frame(NO_TAG, TYPE_IPV4, 4'd5, PROTO_UDP, DEFAULT_PORT, 0, 13, 6'd1);
        steer_frame(TYPE_CTAG, TYPE_IPV4, 4'd5, PROTO_UDP, DEFAULT_PORT, 0, 16, 6'd2);
        steer_frame(NO_TAG, TYPE_IPV4, 4'd5, PROTO_UDP, DEFAULT_PORT, 0, 24, 6'd3);
        steer_frame(NO_TAG, TYPE_IPV4, 4'd15, PROTO_UDP, DEFAULT_PORT, 0, 54, 6'd4);
        steer_frame(NO_TAG, TYPE_IPV6, 4'd5, PROTO_UDP, DEFAULT_PORT, 0, 44, 6'd5);
        steer_frame(NO_TAG, TYPE_IPV4, 4'd5, PROTO_UDP, DEFAULT_PORT, 0, 39, 6'd6);
        // IHL values below the minimum header are malformed.
        steer_frame(NO_TAG, TYPE_IPV4, 4'd3, PROTO_UDP, DEFAULT_PORT, 0, 0, 6'd7);
        steer_frame(NO_TAG, TYPE_IPV4, 4'd0, PROTO_UDP, DEFAULT_PORT, 0, 0, 6'd8);
        // A non-IP type (LLDP), and a second tag behind the first.
        steer_frame(NO_TAG, 16'h88CC, 4'd5, PROTO_UDP, DEFAULT_PORT, 0, 0, 6'd9);
        steer_frame(TYPE_CTAG, TYPE_STAG, 4'd5, PROTO_UDP, DEFAULT_PORT, 0, 0, 6'd10);
        // TCP instead of UDP, then the wrong destination port.
        steer_frame(NO_TAG, TYPE_IPV4, 4'd5, 8'd6, DEFAULT_PORT, 0, 0, 6'd11);
        steer_frame(NO_TAG, TYPE_IPV4, 4'd5, PROTO_UDP, 16'd2056, 0, 0, 6'd12);

        // Highest port value, with a socket on queue 0 only.
        apply_setting(16'hFFFF, 64'h1);
        steer_frame(NO_TAG, TYPE_IPV4, 4'd5, PROTO_UDP, 16'hFFFF, 1, 0, 6'd0);
        steer_frame(NO_TAG, TYPE_IPV6, 4'd5, PROTO_UDP, 16'hFFFF, 1, 0, 6'd1);
        steer_frame(NO_TAG, TYPE_IPV4, 4'd5, PROTO_UDP, DEFAULT_PORT, 1, 0, 6'd0);

        // Random part in four register settings. Most frames are well formed with random
        // headers; the rest are raw noise, odd tags and types, bad IHLs and truncations.
        for (phase = 0; phase < 4; phase++) begin
            case (phase)
                0:       apply_setting(16'd0, '1);
                1:       apply_setting(16'hFFFF, {$urandom, $urandom});
                2:       apply_setting(t_port'($urandom), '0);
                default: apply_setting(t_port'($urandom_range(1, 65535)), {$urandom, $urandom});
            endcase
            // The second setting runs with no idling on either side at all.
            idle_on = (phase != 1);
            f0 = frames_sent;
            b0 = bytes_sent;
            while (bytes_sent - b0 < RANDOM_BYTES / 4 || frames_sent - f0 < PHASE_FRAMES) begin
                // Long receiver hold-off while the following frames keep coming.
                if (phase == 2 && frames_sent == f0) hold_request = 1'b1;
                // The sender stops once until every verdict so far has come back.
                if (phase == 3 && frames_sent - f0 == 1) wait_drained();

                q = t_queue'($urandom_range(0, 63));
                r = $urandom_range(0, 99);
                if (r < 10) begin
                    q = '0;
                end else if (r < 20) begin
                    q = '1;
                end else if (r < 60 && cur_mask != '0) begin
                    while (!cur_mask[q]) q = t_queue'($urandom_range(0, 63));
                end

                if ($urandom_range(0, 99) < 8) begin
                    noise = {};
                    n = $urandom_range(1, 60);
                    repeat (n) noise.push_back(rand_byte());
                    send_frame(noise, q);
                end else begin
                    r = $urandom_range(0, 99);
                    if (r < 70)      tag = NO_TAG;
                    else if (r < 82) tag = TYPE_CTAG;
                    else if (r < 94) tag = TYPE_STAG;
                    else             tag = 16'($urandom);

                    r = $urandom_range(0, 99);
                    if (r < 55)      net = TYPE_IPV4;
                    else if (r < 85) net = TYPE_IPV6;
                    else if (r < 92) net = TYPE_CTAG;
                    else             net = 16'($urandom);

                    r = $urandom_range(0, 99);
                    if (r < 75)      ihl = IHL_MIN;
                    else if (r < 90) ihl = 4'($urandom_range(6, 15));
                    else             ihl = 4'($urandom_range(0, 4));

                    proto = ($urandom_range(0, 99) < 85) ? PROTO_UDP : rand_byte();

                    eff = (cur_port != '0) ? cur_port : DEFAULT_PORT;
                    r = $urandom_range(0, 99);
                    if (r < 65)      dp = eff;
                    else if (r < 75) dp = DEFAULT_PORT;
                    else if (r < 85) dp = t_port'($urandom);
                    else             dp = eff ^ (16'd1 << $urandom_range(0, 15));

                    payload = ($urandom_range(0, 99) < 95) ? $urandom_range(0, 8)
                                                             : $urandom_range(60, 110);
                    cut = ($urandom_range(0, 99) < 85) ? 0 : $urandom_range(1, 60);

                    steer_frame(tag, net, ihl, proto, dp, payload, cut, q);
                end
            end
        end

        idle_on = 1'b0;
        wait_drained();

        $display("Covered %0d frames in %0d byte transfers under %0d register settings; %0d verdicts checked, %0d of them redirects.",
                 frames_sent, bytes_sent, settings_used, verdict_count, redirect_count);
        if (fail_count == 0 && pending == 0) begin
            $display("udp_port_packet_steer_top test passed");
        end else begin
            $display("udp_port_packet_steer_top test failed");
        end
        $finish;
    end

endmodule

>>> files.f
hw/rtl/upps_pkg.sv
hw/rtl/upps_if.sv
hw/rtl/upps_parse.sv
hw/rtl/udp_port_packet_steer_top.sv
tb/sv/upps_steer_checker.sv
tb/sv/udp_port_packet_steer_top_test.sv
